// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the bit engine modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge out of reset
`define ASSERT_HOLDS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/i2cm_pkg.sv -----
// shared types and constants of the i2c master bit engine
package i2cm_pkg;

  localparam int TPD_W = 10;
  localparam int DELAY_W = 11;
  localparam int BYTE_W = 8;
  localparam logic [TPD_W-1:0] TPD_RESET = 10'd25;
  localparam int BITS_PER_BYTE_DEF = 8;
  localparam int QUEUE_DEPTH_DEF = 2;

  // command codes on the input word
  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_PACK  = 3'd5,
    CMD_GACK  = 3'd6
  } cmd_t;

  // class of an input word after decode
  typedef enum logic [1:0] {
    K_TICK  = 2'd0,
    K_START = 2'd1,
    K_STOP  = 2'd2,
    K_SLOT  = 2'd3
  } kind_t;

  // bus sequencer phases
  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_START_SU = 7'b0000010,
    PH_START_HD = 7'b0000100,
    PH_STOP_SU  = 7'b0001000,
    PH_STOP_BUF = 7'b0010000,
    PH_BIT_LOW  = 7'b0100000,
    PH_BIT_HIGH = 7'b1000000
  } phase_t;

  // decoded word carried through the queue
  typedef struct packed {
    kind_t             kind;
    cmd_t              cmd;
    logic              byte_slot;
    logic              first_bit;
    logic [BYTE_W-1:0] tx_byte;
    logic              ack_level;
    logic              sda_level;
  } item_t;

endpackage

// ----- hw/rtl/i2cm_in_if.sv -----
// input channel of the bit engine
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] tx_byte;
  logic       ack_level;
  logic       sda_level;

  modport source (output valid, command, tx_byte, ack_level, sda_level, input ready);
  modport sink (input valid, command, tx_byte, ack_level, sda_level, output ready);
endinterface

// ----- hw/rtl/i2cm_out_if.sv -----
// result channel of the bit engine
interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       nack_seen;

  modport source (output valid, scl_level, sda_drive, busy_res, done_res, rx_byte, nack_seen,
                  input ready);
  modport sink (input valid, scl_level, sda_drive, busy_res, done_res, rx_byte, nack_seen,
                output ready);
endinterface

// ----- hw/rtl/i2cm_cfg_if.sv -----
// configuration write channel of the bit engine
interface i2cm_cfg_if;
  logic       valid;
  logic       ready;
  logic [9:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- hw/rtl/i2cm_front.sv -----
// front end: accepts input words and classifies them for the sequencer
module i2cm_front
  import i2cm_pkg::*;
(
  i2cm_in_if.sink in_ch,
  input  logic    space,
  output logic    push,
  output item_t   push_item
);

  // handshake straight onto the queue
  assign in_ch.ready = space;
  assign push = in_ch.valid & space;

  // decode the command into a class and the first slot bit
  always_comb begin
    push_item.cmd = CMD_TICK;
    push_item.kind = K_TICK;
    push_item.byte_slot = 1'b0;
    push_item.first_bit = 1'b1;
    push_item.tx_byte = in_ch.tx_byte;
    push_item.ack_level = in_ch.ack_level;
    push_item.sda_level = in_ch.sda_level;
    unique case (in_ch.command)
      CMD_START: begin
        push_item.cmd = CMD_START;
        push_item.kind = K_START;
      end
      CMD_STOP: begin
        push_item.cmd = CMD_STOP;
        push_item.kind = K_STOP;
      end
      CMD_WRITE: begin
        push_item.cmd = CMD_WRITE;
        push_item.kind = K_SLOT;
        push_item.byte_slot = 1'b1;
        push_item.first_bit = in_ch.tx_byte[BYTE_W-1];
      end
      CMD_READ: begin
        push_item.cmd = CMD_READ;
        push_item.kind = K_SLOT;
        push_item.byte_slot = 1'b1;
      end
      CMD_PACK: begin
        push_item.cmd = CMD_PACK;
        push_item.kind = K_SLOT;
        push_item.first_bit = in_ch.ack_level;
      end
      CMD_GACK: begin
        push_item.cmd = CMD_GACK;
        push_item.kind = K_SLOT;
      end
      default: begin
        // tick and the unused code both just advance time
        push_item.cmd = CMD_TICK;
        push_item.kind = K_TICK;
      end
    endcase
  end

endmodule

// ----- hw/rtl/i2cm_queue.sv -----
// short queue of decoded words between front end and sequencer
`include "assert_macros.svh"
module i2cm_queue
  import i2cm_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  space,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign space = (count_r != CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item = mem_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    count_nxt = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `ASSERT_HOLDS(a_no_underflow, !(pop && (count_r == '0)), "pop from empty queue")
  `ASSERT_NEXT(a_fill_up, push && !pop, count_r == $past(count_r) + CNT_W'(1), "fill count lost a push")

endmodule

// ----- hw/rtl/i2cm_back.sv -----
// back end: scl/sda phase sequencer and result register
`include "assert_macros.svh"
module i2cm_back
  import i2cm_pkg::*;
#(
  parameter int BITS_PER_BYTE = BITS_PER_BYTE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  item_t       head_item,
  output logic        pop,
  i2cm_cfg_if.sink    cfg_ch,
  i2cm_out_if.source  out_ch
);

  localparam int CNT_W = $clog2(BITS_PER_BYTE + 1);

  // sequencer state
  phase_t              phase_r, phase_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic                byte_r, byte_nxt;
  logic [CNT_W-1:0]    bit_cnt_r, bit_cnt_nxt;
  logic [BYTE_W-1:0]   shift_r, shift_nxt;
  logic [DELAY_W-1:0]  delay_r, delay_nxt;
  logic                scl_r, scl_nxt;
  logic                sda_r, sda_nxt;
  logic                nack_r, nack_nxt;
  logic [TPD_W-1:0]    tpd_r;

  // result register
  logic                ov_r, ov_nxt;
  logic                done_c;
  logic [BYTE_W-1:0]   rx_c;
  logic                nack_out_c;

  // timing helpers
  logic [TPD_W-1:0]    unit_len;
  logic [DELAY_W-1:0]  phase_len;
  logic [DELAY_W-1:0]  delay_inc;
  logic                phase_end;
  logic [CNT_W-1:0]    slots;

  function automatic logic slot_bit(cmd_t c, logic [BYTE_W-1:0] sh, logic nk);
    logic b;
    b = 1'b1;
    if (c == CMD_WRITE) b = sh[BYTE_W-1];
    else if (c == CMD_PACK) b = nk;
    return b;
  endfunction

  // take a word whenever the result register frees up
  assign pop = head_valid & (~ov_r | out_ch.ready);
  assign cfg_ch.ready = 1'b1;

  // phase length in ticks, zero setting counts as one
  assign unit_len = (tpd_r == '0) ? TPD_W'(1) : tpd_r;
  assign phase_len = (phase_r == PH_STOP_BUF || phase_r == PH_BIT_LOW) ?
                     {unit_len, 1'b0} : {1'b0, unit_len};
  assign delay_inc = delay_r + DELAY_W'(1);
  assign phase_end = (delay_inc >= phase_len);
  assign slots = byte_r ? CNT_W'(BITS_PER_BYTE) : CNT_W'(1);

  // next state for the word at the queue head
  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt = cmd_r;
    byte_nxt = byte_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt = shift_r;
    delay_nxt = delay_r;
    scl_nxt = scl_r;
    sda_nxt = sda_r;
    nack_nxt = nack_r;
    done_c = 1'b0;
    rx_c = '0;
    nack_out_c = 1'b0;
    if (phase_r == PH_IDLE) begin
      if (head_item.kind != K_TICK) begin
        cmd_nxt = head_item.cmd;
        byte_nxt = head_item.byte_slot;
        bit_cnt_nxt = '0;
        delay_nxt = '0;
        unique case (head_item.kind)
          K_START: begin
            scl_nxt = 1'b1;
            sda_nxt = 1'b1;
            phase_nxt = PH_START_SU;
          end
          K_STOP: begin
            scl_nxt = 1'b1;
            sda_nxt = 1'b0;
            phase_nxt = PH_STOP_SU;
          end
          default: begin
            shift_nxt = (head_item.cmd == CMD_WRITE) ? head_item.tx_byte : '0;
            if (head_item.cmd == CMD_PACK) nack_nxt = head_item.ack_level;
            else if (head_item.cmd == CMD_GACK) nack_nxt = 1'b0;
            scl_nxt = 1'b0;
            sda_nxt = head_item.first_bit;
            phase_nxt = PH_BIT_LOW;
          end
        endcase
      end
    end else begin
      // sample sda on the first tick with scl high
      if (phase_r == PH_BIT_HIGH && delay_r == '0) begin
        if (cmd_r == CMD_READ) shift_nxt = {shift_r[BYTE_W-2:0], head_item.sda_level};
        else if (cmd_r == CMD_GACK) nack_nxt = head_item.sda_level;
      end
      delay_nxt = delay_inc;
      if (phase_end) begin
        delay_nxt = '0;
        unique case (phase_r)
          PH_START_SU: begin
            sda_nxt = 1'b0;
            phase_nxt = PH_START_HD;
          end
          PH_START_HD: begin
            scl_nxt = 1'b0;
            phase_nxt = PH_IDLE;
            done_c = 1'b1;
          end
          PH_STOP_SU: begin
            sda_nxt = 1'b1;
            phase_nxt = PH_STOP_BUF;
          end
          PH_STOP_BUF: begin
            phase_nxt = PH_IDLE;
            done_c = 1'b1;
          end
          PH_BIT_LOW: begin
            scl_nxt = 1'b1;
            if (cmd_r == CMD_WRITE) shift_nxt = {shift_r[BYTE_W-2:0], 1'b0};
            phase_nxt = PH_BIT_HIGH;
          end
          PH_BIT_HIGH: begin
            bit_cnt_nxt = bit_cnt_r + CNT_W'(1);
            scl_nxt = 1'b0;
            if (bit_cnt_nxt >= slots) begin
              phase_nxt = PH_IDLE;
              done_c = 1'b1;
              if (cmd_r == CMD_READ) rx_c = shift_nxt;
              if (cmd_r == CMD_GACK) nack_out_c = nack_nxt;
            end else begin
              sda_nxt = slot_bit(cmd_r, shift_nxt, nack_nxt);
              phase_nxt = PH_BIT_LOW;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

  assign ov_nxt = pop | (ov_r & ~out_ch.ready);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cmd_r <= CMD_TICK;
      byte_r <= 1'b0;
      bit_cnt_r <= '0;
      shift_r <= '0;
      delay_r <= '0;
      scl_r <= 1'b1;
      sda_r <= 1'b1;
      nack_r <= 1'b0;
      tpd_r <= TPD_RESET;
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      if (cfg_ch.valid) begin
        tpd_r <= cfg_ch.data;
      end
      if (pop) begin
        phase_r <= phase_nxt;
        cmd_r <= cmd_nxt;
        byte_r <= byte_nxt;
        bit_cnt_r <= bit_cnt_nxt;
        shift_r <= shift_nxt;
        delay_r <= delay_nxt;
        scl_r <= scl_nxt;
        sda_r <= sda_nxt;
        nack_r <= nack_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      out_ch.scl_level <= scl_nxt;
      out_ch.sda_drive <= sda_nxt;
      out_ch.busy_res <= (phase_nxt != PH_IDLE);
      out_ch.done_res <= done_c;
      out_ch.rx_byte <= rx_c;
      out_ch.nack_seen <= nack_out_c;
    end
  end

  assign out_ch.valid = ov_r;

  `ASSERT_NEXT(a_done_idle, pop && done_c, phase_r == PH_IDLE, "done without return to idle")
  `ASSERT_NEXT(a_idle_tick, pop && (phase_r == PH_IDLE) && (head_item.kind == K_TICK), (phase_r == PH_IDLE) && $stable(scl_r) && $stable(sda_r), "idle tick changed the bus")
  `ASSERT_NEXT(a_slot_low, pop && (phase_r == PH_IDLE) && (head_item.kind == K_SLOT), !scl_r && (phase_r == PH_BIT_LOW), "bit slot did not pull scl low")

endmodule

// ----- hw/rtl/i2c_master_bit_engine_core.sv -----
// top level of the i2c master bit engine
// Usage:
//   in_ch carries one word per clock while in_ch.ready is high: a tick (command 0) or a bus command
//   (start, stop, write byte, read byte, send ack, get ack) with its byte,
//   ack level and the SDA level sampled for that tick. A command given
//   while a sequence runs counts as a tick.
//   out_ch returns one word for every input word: the SCL and SDA drive
//   levels (1 released), busy, a done pulse, the read byte and nack bit.
//   cfg_ch sets ticks_per_delay; write it only while the engine is idle.
// Timing:
//   one input word per cycle sustained while out_ch takes every result;
//   a word accepted on in_ch is written into the queue, and then the
//   sequencer's next-state step, which handles one tick per clock,
//   loads its result into the result register, where out_ch takes it.
// Reset leaves both lines released, the engine idle and ticks_per_delay 25.
// When out_ch stalls the result register holds its word and the queue
// keeps taking input until it is full, then in_ch.ready drops.
module i2c_master_bit_engine_core
  import i2cm_pkg::*;
#(
  parameter int BITS_PER_BYTE = BITS_PER_BYTE_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  i2cm_in_if.sink    in_ch,
  i2cm_cfg_if.sink   cfg_ch,
  i2cm_out_if.source out_ch
);

  logic  push;
  item_t push_item;
  logic  space;
  logic  pop;
  logic  head_valid;
  item_t head_item;

  // classify incoming words
  i2cm_front u_front (
    .in_ch     (in_ch),
    .space     (space),
    .push      (push),
    .push_item (push_item)
  );

  // decouple front from sequencer
  i2cm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .space      (space),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // run the bus phases
  i2cm_back #(
    .BITS_PER_BYTE (BITS_PER_BYTE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .cfg_ch     (cfg_ch),
    .out_ch     (out_ch)
  );

endmodule
